FILE: rtl/encds_pkg.sv
// shared types and constants for the encoder delta and speed tracker
`timescale 1ns / 1ps
package encds_pkg;

  // apb register map
  localparam int unsigned PADDR_W = 3;
  localparam logic [PADDR_W-1:0] CPR_ADDR = 3'd0;
  localparam logic [15:0] CPR_RESET = 16'd1024;

  // request codes
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  // speed arithmetic
  localparam logic [31:0] SPEED_SCALE = 32'd600000;
  localparam int unsigned PROD_W = 48;
  localparam int unsigned DIV_STEPS = 48;
  localparam int unsigned CNT_W = 6;

  typedef struct packed {
    logic        req_type;
    logic [1:0]  channel;
    logic [15:0] raw_count;
    logic [31:0] interval_ms;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] delta;
    logic signed [31:0] total;
    logic signed [31:0] speed_rpm_x10;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_DEN,
    ST_MUL_MAG,
    ST_ADD,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

FILE: rtl/encoder_delta_and_speed.sv
// encoder delta, running total and speed tracker with iterative divider
`timescale 1ns / 1ps
// sequence: a speed sample makes 2 multiply passes through one shared 16x32 multiplier, then
// 1 rounding add, 48 restoring divide steps and 1 output load; clears, out-of-range channels
// and zero-speed cases skip the multiply and divide steps and go straight to the output load.
// flow: one transaction at a time; the input stalls from acceptance until the result is loaded
// into the output register, so a stalled result keeps the input stalled for its wait.
// reset: all channel counts and totals clear to zero at once, counts_per_rev to 1024.
module encoder_delta_and_speed
  import encds_pkg::*;
#(
  parameter int unsigned CHANNELS = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // sample channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_item_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_item_o,
  // apb configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [4:0] CH_LIMIT = 5'(CHANNELS);

  // configuration register
  logic [15:0] cpr_q;
  logic        cpr_sel;

  // per-channel state
  logic [15:0] last_q  [CHANNELS];
  logic [31:0] total_q [CHANNELS];

  // sequencer and datapath registers
  state_e            state_q, state_d;
  logic [15:0]       delta_q;
  logic [31:0]       tot_res_q;
  logic              skip_q;
  logic              neg_q;
  logic [15:0]       absd_q;
  logic [15:0]       cpr_op_q;
  logic [31:0]       elapsed_q;
  logic [PROD_W-1:0] den_q;
  logic [PROD_W-1:0] nq_q;
  logic [PROD_W-1:0] rem_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              out_valid_q;
  out_item_t         out_q;

  // control from the sequencer
  logic in_fire, out_fire, load_out, div_last;

  // request decode
  logic [4:0]      ch_ext;
  logic            ch_ok;
  logic [CH_W-1:0] ch_idx;
  logic [15:0]     dbits;
  logic [31:0]     new_total;

  assign ch_ext    = {3'b000, in_item_i.channel};
  assign ch_ok     = ch_ext < CH_LIMIT;
  assign ch_idx    = ch_ext[CH_W-1:0];
  assign dbits     = in_item_i.raw_count - last_q[ch_idx];
  assign new_total = total_q[ch_idx] + {{16{dbits[15]}}, dbits};

  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_fire = out_valid_q && !out_stall_i;
  assign div_last = cnt_q == CNT_W'(DIV_STEPS - 1);

  // apb register file, decoded by word
  assign pready  = 1'b1;
  assign cpr_sel = paddr[PADDR_W-1:2] == CPR_ADDR[PADDR_W-1:2];
  assign prdata  = cpr_sel ? {16'h0000, cpr_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpr_q <= CPR_RESET;
    end else if (psel && penable && pwrite && pready && cpr_sel) begin
      cpr_q <= pwdata[15:0];
    end
  end

  // shared multiplier: denominator first, then scaled magnitude
  logic [15:0]       mul_a;
  logic [31:0]       mul_b;
  logic [PROD_W-1:0] mul_res;

  assign mul_a   = (state_q == ST_MUL_DEN) ? cpr_op_q : absd_q;
  assign mul_b   = (state_q == ST_MUL_DEN) ? elapsed_q : SPEED_SCALE;
  assign mul_res = PROD_W'(mul_a) * PROD_W'(mul_b);

  // restoring divide step
  logic [PROD_W:0]   trial;
  logic              q_bit;
  logic [PROD_W-1:0] rem_next;

  assign trial    = {rem_q, nq_q[PROD_W-1]};
  assign q_bit    = trial >= {1'b0, den_q};
  assign rem_next = q_bit ? PROD_W'(trial - {1'b0, den_q}) : trial[PROD_W-1:0];

  // saturated signed speed from the quotient
  logic [31:0] speed;

  always_comb begin
    if (skip_q) begin
      speed = 32'h0;
    end else if (neg_q) begin
      speed = (nq_q > PROD_W'(32'h8000_0000)) ? 32'h8000_0000 : 32'(0 - nq_q[31:0]);
    end else begin
      speed = (|nq_q[PROD_W-1:31]) ? 32'h7fff_ffff : {1'b0, nq_q[30:0]};
    end
  end

  // channel state update on accepted requests
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        last_q[i]  <= '0;
        total_q[i] <= '0;
      end
    end else if (in_fire && ch_ok) begin
      if (in_item_i.req_type == REQ_CLEAR) begin
        last_q[ch_idx]  <= '0;
        total_q[ch_idx] <= '0;
      end else begin
        last_q[ch_idx]  <= in_item_i.raw_count;
        total_q[ch_idx] <= new_total;
      end
    end
  end

  // working registers of the speed computation
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          cpr_op_q  <= cpr_q;
          elapsed_q <= in_item_i.interval_ms;
          neg_q     <= dbits[15];
          absd_q    <= dbits[15] ? 16'(0 - dbits) : dbits;
          if (!ch_ok || in_item_i.req_type == REQ_CLEAR) begin
            delta_q   <= '0;
            tot_res_q <= '0;
            skip_q    <= 1'b1;
          end else begin
            delta_q   <= dbits;
            tot_res_q <= new_total;
            skip_q    <= (in_item_i.interval_ms == 32'h0) || (cpr_q == 16'h0);
          end
        end
      end
      ST_MUL_DEN: den_q <= mul_res;
      ST_MUL_MAG: nq_q  <= mul_res;
      ST_ADD: begin
        nq_q  <= nq_q + (den_q >> 1);
        rem_q <= '0;
        cnt_q <= '0;
      end
      ST_DIV: begin
        rem_q <= rem_next;
        nq_q  <= {nq_q[PROD_W-2:0], q_bit};
        cnt_q <= cnt_q + 1'b1;
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  // sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (!ch_ok || in_item_i.req_type == REQ_CLEAR ||
              in_item_i.interval_ms == 32'h0 || cpr_q == 16'h0) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_MUL_DEN;
          end
        end
      end
      ST_MUL_DEN: state_d = ST_MUL_MAG;
      ST_MUL_MAG: state_d = ST_ADD;
      ST_ADD:     state_d = ST_DIV;
      ST_DIV: begin
        if (div_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    load_out   = 1'b0;
    unique case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_DONE: load_out = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.delta         <= delta_q;
      out_q.total         <= tot_res_q;
      out_q.speed_rpm_x10 <= speed;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // ready only while the sequencer is idle
  a_stall_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> state_q == ST_IDLE)
    else $error("input taken while sequencer busy");

  // an accepted transaction always leaves idle
  a_fire_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q != ST_IDLE)
    else $error("accepted transaction lost");

  // divide loop never runs past its last step
  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV && div_last |=> state_q == ST_DONE)
    else $error("divide loop overrun");

  // a result is loaded only when the output slot is free or draining
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> !out_valid_q || !out_stall_i)
    else $error("pending result overwritten");

endmodule

FILE: tb/sv/encds_result_checker.sv
// result checker: predicts delta, total and speed per channel and compares each transaction
`timescale 1ns / 1ps
module encds_result_checker
  import encds_pkg::*;
#(
  parameter int unsigned CHANNELS = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // sample channel
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  in_item_t           in_item_i,
  // result channel
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  out_item_t          out_item_i,
  // apb writes, watched to track counts_per_rev
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic               pready_i,
  input  logic [PADDR_W-1:0] paddr_i,
  input  logic [31:0]        pwdata_i,
  // run status
  output int                 err_count_o,
  output int                 pending_o,
  output int                 checked_o,
  output int                 saturated_o
);

  localparam logic [63:0] MAX_POS_MAG = 64'd2147483647;
  localparam logic [63:0] MAX_NEG_MAG = 64'd2147483648;

  // predicted channel state and configuration
  logic [15:0] last_raw  [CHANNELS];
  logic [31:0] total_acc [CHANNELS];
  logic [15:0] cpr_q;

  // results predicted but not yet seen, oldest first
  out_item_t   due_results [$];
  int          mismatches;
  int          checked;
  int          saturated;

  // tenths of rpm, rounded half away from zero, clamped to 32 bits
  function automatic logic [31:0] speed_tenths(logic [15:0] d, logic [31:0] el);
    logic [63:0] den;
    logic [63:0] mag;
    logic [63:0] q;
    logic        neg;
    int          dv;
    if (el == 32'd0 || cpr_q == 16'd0) return 32'd0;
    den = 64'(cpr_q) * 64'(el);
    neg = d[15];
    dv  = int'($signed(d));
    mag = 64'(neg ? -dv : dv) * 64'(SPEED_SCALE);
    q   = (mag + den / 64'd2) / den;
    if (neg) begin
      if (q > MAX_NEG_MAG) q = MAX_NEG_MAG;
      return 32'd0 - q[31:0];
    end
    if (q > MAX_POS_MAG) q = MAX_POS_MAG;
    return q[31:0];
  endfunction

  // apply one request to the channel state and return its result
  function automatic out_item_t track_channel(in_item_t it);
    out_item_t   res;
    logic [15:0] diff;
    res = '0;
    if (it.channel >= CHANNELS) return res;
    if (it.req_type == REQ_CLEAR) begin
      last_raw[it.channel]  = '0;
      total_acc[it.channel] = '0;
      return res;
    end
    diff = it.raw_count - last_raw[it.channel];
    last_raw[it.channel]  = it.raw_count;
    total_acc[it.channel] = total_acc[it.channel] + {{16{diff[15]}}, diff};
    res.delta         = diff;
    res.total         = total_acc[it.channel];
    res.speed_rpm_x10 = speed_tenths(diff, it.interval_ms);
    return res;
  endfunction

  task automatic flag_field(input string field, input longint want, input longint got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  // watch both channels and the config port at every edge
  always @(posedge clk_i) begin
    out_item_t want;
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        last_raw[c]  = '0;
        total_acc[c] = '0;
      end
      cpr_q = CPR_RESET;
      due_results.delete();
      mismatches = 0;
      checked    = 0;
      saturated  = 0;
    end else begin
      // result transaction against the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t ns: result with nothing expected, delta %0d total %0d speed %0d",
                     $time, out_item_i.delta, out_item_i.total, out_item_i.speed_rpm_x10);
          end
        end else begin
          want = due_results.pop_front();
          checked++;
          if (out_item_i.delta !== want.delta) begin
            flag_field("delta", longint'(want.delta), longint'(out_item_i.delta));
          end
          if (out_item_i.total !== want.total) begin
            flag_field("total", longint'(want.total), longint'(out_item_i.total));
          end
          if (out_item_i.speed_rpm_x10 !== want.speed_rpm_x10) begin
            flag_field("speed_rpm_x10", longint'(want.speed_rpm_x10),
                       longint'(out_item_i.speed_rpm_x10));
          end
        end
      end
      // sample transaction, seen with the divisor held before this edge
      if (in_valid_i && !in_stall_i) begin
        want = track_channel(in_item_i);
        if (want.speed_rpm_x10 == 32'sh7FFFFFFF || want.speed_rpm_x10 == 32'sh80000000) begin
          saturated++;
        end
        due_results.push_back(want);
      end
      // register write
      if (psel_i && penable_i && pwrite_i && pready_i &&
          paddr_i[PADDR_W-1:2] == CPR_ADDR[PADDR_W-1:2]) begin
        cpr_q = pwdata_i[15:0];
      end
    end
    err_count_o <= mismatches;
    pending_o   <= due_results.size();
    checked_o   <= checked;
    saturated_o <= saturated;
  end

endmodule

FILE: tb/sv/tb_encoder_delta_and_speed.sv
// testbench top: stimulus, receiver stalls and verdict for the encoder delta and speed tracker
`timescale 1ns / 1ps
module tb_encoder_delta_and_speed
  import encds_pkg::*;
();

  localparam int unsigned NCH           = 4;
  localparam int unsigned SETTLE_CYCLES = 60;
  localparam int unsigned PHASE_ITEMS   = 215;
  localparam int unsigned IDLE_PCT      = 38;
  localparam int unsigned HOLD_AT       = 400;
  localparam int unsigned HOLD_CYCLES   = 600;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  in_item_t           in_item_i   = '0;
  logic               in_stall_o;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  out_item_t          out_item_o;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [PADDR_W-1:0] paddr       = '0;
  logic [31:0]        pwdata      = '0;
  logic [31:0]        prdata;
  logic               pready;

  int                 err_count;
  int                 pending;
  int                 checked;
  int                 saturated;

  // stimulus bookkeeping
  logic [15:0]        prev_raw [NCH];
  logic               quiet_tx     = 1'b0;
  int                 sent_samples = 0;
  int                 sent_clears  = 0;
  int                 cpr_writes   = 0;

  // receiver bookkeeping
  int                 rx_count     = 0;
  int                 hold_left    = 0;
  logic               hold_done    = 1'b0;

  encoder_delta_and_speed #(
    .CHANNELS (NCH)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  encds_result_checker #(
    .CHANNELS (NCH)
  ) checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_i  (out_item_o),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .err_count_o (err_count),
    .pending_o   (pending),
    .checked_o   (checked),
    .saturated_o (saturated)
  );

  // 12 ns clock
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // run limit
  initial begin
    #12_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // receiver: random stalls, one long hold-off, one calm stretch
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) rx_count <= rx_count + 1;
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (!hold_done && rx_count == HOLD_AT) begin
      out_stall_i <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      hold_done   <= 1'b1;
    end else if (rx_count >= 700 && rx_count < 900) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < IDLE_PCT);
    end
  end

  function automatic in_item_t mk(logic rq, logic [1:0] ch, logic [15:0] raw, logic [31:0] el);
    in_item_t it;
    it.req_type    = rq;
    it.channel     = ch;
    it.raw_count   = raw;
    it.interval_ms = el;
    return it;
  endfunction

  // mostly plausible encoder motion, some clears and some raw noise
  function automatic in_item_t random_item();
    int unsigned pick;
    logic [1:0]  ch;
    logic [15:0] raw;
    logic [31:0] el;
    int          step;
    pick = $urandom_range(99);
    ch   = 2'($urandom_range(NCH - 1));
    if (pick < 6) return mk(REQ_CLEAR, ch, 16'($urandom), $urandom);
    if (pick < 12) return mk(1'($urandom), ch, 16'($urandom), $urandom);
    pick = $urandom_range(99);
    if (pick < 60) begin
      step = int'($urandom_range(400)) - 200;
      raw  = prev_raw[ch] + 16'(step);
    end else if (pick < 85) begin
      step = int'($urandom_range(8000)) - 4000;
      raw  = prev_raw[ch] + 16'(step);
    end else begin
      raw = 16'($urandom);
    end
    pick = $urandom_range(99);
    if (pick < 8) el = 32'd0;
    else if (pick < 13) el = $urandom;
    else if (pick < 16) el = 32'hFFFF_FFFF;
    else el = $urandom_range(50, 1);
    return mk(REQ_SAMPLE, ch, raw, el);
  endfunction

  // offer one transaction, idling first at random; valid stays high after acceptance
  task automatic send_item(input in_item_t it);
    if (!quiet_tx && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < IDLE_PCT) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    if (it.req_type == REQ_CLEAR) begin
      prev_raw[it.channel] = '0;
      sent_clears++;
    end else begin
      prev_raw[it.channel] = it.raw_count;
      sent_samples++;
    end
  endtask

  // drain all results, let the block settle, then write counts_per_rev
  task automatic set_cpr(input logic [15:0] v);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CPR_ADDR;
    pwdata  <= {16'($urandom), v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cpr_writes++;
  endtask

  initial begin : stimulus
    logic [15:0] cpr_plan [6];
    for (int c = 0; c < NCH; c++) prev_raw[c] = '0;
    cpr_plan = '{16'd1, 16'd65535, 16'd360, 16'($urandom_range(65535, 1)), 16'd4096,
                 CPR_RESET};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, clears and zero elapsed at the reset divisor
    send_item(mk(REQ_SAMPLE, 2'd0, 16'h0000, 32'd0));
    send_item(mk(REQ_SAMPLE, 2'd0, 16'h7FFF, 32'd1));
    send_item(mk(REQ_SAMPLE, 2'd0, 16'hFFFF, 32'd100));
    send_item(mk(REQ_SAMPLE, 2'd0, 16'h0000, 32'hFFFF_FFFF));
    send_item(mk(REQ_SAMPLE, 2'd1, 16'hFFFF, 32'd10));
    send_item(mk(REQ_CLEAR,  2'd1, 16'h1234, 32'd5));
    send_item(mk(REQ_SAMPLE, 2'd1, 16'h8000, 32'd1));
    send_item(mk(REQ_SAMPLE, 2'd2, 16'h0001, 32'd1));
    send_item(mk(REQ_SAMPLE, 2'd3, 16'hAAAA, 32'h5555_5555));
    send_item(mk(REQ_SAMPLE, 2'd3, 16'h5555, 32'hAAAA_AAAA));
    send_item(mk(REQ_CLEAR,  2'd2, 16'hFFFF, 32'hFFFF_FFFF));
    send_item(mk(REQ_CLEAR,  2'd3, 16'h0000, 32'd0));

    // directed: saturation both ways and rounding of exact halves with one count per rev
    set_cpr(16'd1);
    send_item(mk(REQ_SAMPLE, 2'd0, 16'h7FFF, 32'd1));
    send_item(mk(REQ_SAMPLE, 2'd0, 16'hFFFF, 32'd1));
    send_item(mk(REQ_SAMPLE, 2'd0, 16'hFFFF, 32'd1));
    send_item(mk(REQ_SAMPLE, 2'd1, 16'h8001, 32'd400000));
    send_item(mk(REQ_SAMPLE, 2'd1, 16'h8000, 32'd400000));

    // directed: zero counts per rev gives no speed
    set_cpr(16'd0);
    send_item(mk(REQ_SAMPLE, 2'd2, 16'h0100, 32'd7));
    send_item(mk(REQ_SAMPLE, 2'd3, 16'hF000, 32'd3));

    // random phases over several divisors
    for (int p = 0; p < 6; p++) begin
      set_cpr(cpr_plan[p]);
      quiet_tx = (p == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == 150) quiet_tx = 1'b0;
        send_item(random_item());
      end
    end

    // drain and settle
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("coverage: %0d samples and %0d clears sent, %0d results checked",
             sent_samples, sent_clears, checked);
    $display("coverage: %0d counts_per_rev writes, %0d saturated speeds predicted",
             cpr_writes, saturated);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
